[sv/lits_pkg.sv]
// lits_pkg: widths, types and constants shared by the time-stretch resampler.
// No dependencies; every other file imports this package.
package lits_pkg;

    localparam int PHASE_FRAC_BITS = 16;
    localparam int SAMPLE_BITS     = 16;
    localparam int STEP_BITS       = 18;
    localparam int MAX_RESULTS     = 64;

    localparam int PHASE_BITS = PHASE_FRAC_BITS + 2;
    localparam int CNT_BITS   = $clog2(MAX_RESULTS + 1);
    localparam int NUM_BITS   = SAMPLE_BITS + PHASE_FRAC_BITS + 2;

    typedef logic [PHASE_BITS-1:0]         t_phase;
    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [STEP_BITS-1:0]          t_step_cfg;
    typedef logic [CNT_BITS-1:0]           t_cnt;

    localparam t_phase PHASE_ONE = t_phase'(1) << PHASE_FRAC_BITS;
    localparam t_phase STEP_MAX  = t_phase'(2) << PHASE_FRAC_BITS;
    localparam t_cnt   CNT_MAX   = t_cnt'(MAX_RESULTS);

    // control from the sequencer to the multiply/round unit
    typedef struct packed {
        logic mul_en;
        logic sum_en;
    } t_mac_ctrl;

endpackage

[sv/lits_if.sv]
// Valid/ready stream interfaces for the input and output words.
// Depends on lits_pkg for the sample width.
interface lits_in_if import lits_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample_in;
    logic    stream_last;

    modport source (output valid, output sample_in, output stream_last, input ready);
    modport sink   (input valid, input sample_in, input stream_last, output ready);
endinterface

interface lits_out_if import lits_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample_out;
    logic    run_last;
    logic    stream_end;

    modport source (output valid, output sample_out, output run_last, output stream_end,
                    input ready);
    modport sink   (input valid, input sample_out, input run_last, input stream_end,
                    output ready);
endinterface

[sv/lits_mac.sv]
// lits_mac: shared multiply, accumulate and round unit for one interpolated sample.
// Depends on lits_pkg.
module lits_mac import lits_pkg::*; (
    input  logic                       i_clk,
    input  t_mac_ctrl                  i_ctrl,
    input  t_sample                    i_prev,
    input  t_sample                    i_cur,
    input  logic [PHASE_FRAC_BITS-1:0] i_frac,
    output t_sample                    o_value
);

    localparam logic signed [NUM_BITS-1:0] HALF = NUM_BITS'(1) << (PHASE_FRAC_BITS - 1);
    localparam logic signed [SAMPLE_BITS+1:0] Q_MAX = (SAMPLE_BITS+2)'((1 << (SAMPLE_BITS-1)) - 1);
    localparam logic signed [SAMPLE_BITS+1:0] Q_MIN = -Q_MAX - (SAMPLE_BITS+2)'(1);

    logic signed [SAMPLE_BITS:0]      diff;
    logic signed [NUM_BITS-1:0]       r_prod;
    logic signed [NUM_BITS-1:0]       r_num;
    logic signed [NUM_BITS-1:0]       base;
    logic signed [NUM_BITS-1:0]       bias;
    logic signed [NUM_BITS-1:0]       rounded;
    logic signed [SAMPLE_BITS+1:0]    q;

    assign diff = {i_cur[SAMPLE_BITS-1], i_cur} - {i_prev[SAMPLE_BITS-1], i_prev};
    assign base = {{2{i_prev[SAMPLE_BITS-1]}}, i_prev, {PHASE_FRAC_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= NUM_BITS'(diff) * NUM_BITS'($signed({1'b0, i_frac}));
        end
        if (i_ctrl.sum_en) begin
            r_num <= base + r_prod;
        end
    end

    // half away from zero: negative values round with half minus one, then floor
    assign bias    = r_num[NUM_BITS-1] ? (HALF - NUM_BITS'(1)) : HALF;
    assign rounded = r_num + bias;
    assign q       = rounded[NUM_BITS-1:PHASE_FRAC_BITS];

    always_comb begin
        if (q > Q_MAX) begin
            o_value = Q_MAX[SAMPLE_BITS-1:0];
        end else if (q < Q_MIN) begin
            o_value = Q_MIN[SAMPLE_BITS-1:0];
        end else begin
            o_value = q[SAMPLE_BITS-1:0];
        end
    end

endmodule

[sv/linear_interp_time_stretch.sv]
// Linear interpolation time-stretch resampler, top level with the sequencer.
// Depends on lits_pkg, lits_if (lits_in_if, lits_out_if) and lits_mac.
//
// Usage: signed samples arrive as words on i_in (valid/ready); stream_last marks
// the last sample of a waveform. Each sample yields every output word whose
// source position lies before it, interpolated as prev + (cur - prev) * frac,
// rounded half away from zero. On the last sample, trailing words repeat it.
// run_last flags the last word caused by one input; stream_end the last word
// of a stream. i_cfg_we/i_cfg_data write the Q16 source step (1/factor).
// Timing: one input at a time; i_in.ready is high only while idle. An
// interpolated word passes multiply, accumulate and round through the one
// shared multiply unit, a trailing word is pushed straight from S_TRAIL, and each
// input passes accept, phase wrap and flush; the first sample of a stream has no
// wrap step and a last sample adds a step in S_TRAIL to end its trailing run.
// Past 64 words per input, each skipped position still advances the phase by one step.
// One word is held back internally until the run ends so its flags are known;
// a stalled receiver holds the output register and the sequencer waits.
// Reset: step returns to 1.0, phase and previous sample clear, output empties.
module linear_interp_time_stretch import lits_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  t_step_cfg         i_cfg_data,
    lits_in_if.sink           i_in,
    lits_out_if.source        o_out
);

    localparam int CMP_BITS = STEP_BITS + PHASE_BITS;
    localparam int TR_BITS  = PHASE_BITS + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INTERP,
        S_SUM,
        S_PUSH,
        S_TRAIL,
        S_FLUSH
    } t_state;

    t_state    r_state;
    t_phase    r_step;
    t_phase    r_phase;
    t_sample   r_prev;
    t_sample   r_cur;
    logic      r_have;
    logic      r_last;
    t_cnt      r_cnt;
    logic      r_pend_valid;
    t_sample   r_pend_data;
    logic      r_out_valid;
    t_sample   r_out_data;
    logic      r_out_run_last;
    logic      r_out_end;

    t_mac_ctrl             mac_ctrl;
    t_sample               mac_value;
    logic [CMP_BITS-1:0]   cfg_wide;
    t_phase                n_step;
    logic [TR_BITS-1:0]    trail_sum;
    logic                  trail_ok;
    logic                  out_free;
    logic                  n_push;
    t_sample               n_push_data;

    lits_mac u_mac (
        .i_clk   (i_clk),
        .i_ctrl  (mac_ctrl),
        .i_prev  (r_prev),
        .i_cur   (r_cur),
        .i_frac  (r_phase[PHASE_FRAC_BITS-1:0]),
        .o_value (mac_value)
    );

    // step of zero acts as one LSB, above 2.0 as 2.0
    always_comb begin
        cfg_wide = CMP_BITS'(i_cfg_data);
        if (cfg_wide == '0) begin
            n_step = t_phase'(1);
        end else if (cfg_wide > CMP_BITS'(STEP_MAX)) begin
            n_step = STEP_MAX;
        end else begin
            n_step = cfg_wide[PHASE_BITS-1:0];
        end
    end

    assign trail_sum = (TR_BITS'(r_phase) << 1) + TR_BITS'(r_step);
    assign trail_ok  = (trail_sum <= (TR_BITS'(PHASE_ONE) << 1)) && (r_cnt != CNT_MAX);
    assign out_free  = !r_out_valid || o_out.ready;

    always_comb begin
        mac_ctrl.mul_en = (r_state == S_INTERP) && (r_phase < PHASE_ONE) && (r_cnt != CNT_MAX);
        mac_ctrl.sum_en = (r_state == S_SUM);
        n_push = ((r_state == S_PUSH) || ((r_state == S_TRAIL) && trail_ok))
                 && (!r_pend_valid || out_free);
        n_push_data = (r_state == S_TRAIL) ? r_cur : mac_value;
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_data;
    assign o_out.run_last   = r_out_run_last;
    assign o_out.stream_end = r_out_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_step       <= PHASE_ONE;
            r_phase      <= '0;
            r_prev       <= '0;
            r_have       <= 1'b0;
            r_last       <= 1'b0;
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_step <= n_step;
            end
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            // a new word moves the held one to the output register
            if (n_push) begin
                if (r_pend_valid) begin
                    r_out_valid    <= 1'b1;
                    r_out_data     <= r_pend_data;
                    r_out_run_last <= 1'b0;
                    r_out_end      <= 1'b0;
                end
                r_pend_valid <= 1'b1;
                r_pend_data  <= n_push_data;
                r_phase      <= r_phase + r_step;
                r_cnt        <= r_cnt + t_cnt'(1);
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_cur  <= i_in.sample_in;
                        r_last <= i_in.stream_last;
                        r_cnt  <= '0;
                        if (r_have) begin
                            r_state <= S_INTERP;
                        end else begin
                            r_phase <= '0;
                            r_prev  <= i_in.sample_in;
                            r_have  <= 1'b1;
                            r_state <= i_in.stream_last ? S_TRAIL : S_FLUSH;
                        end
                    end
                end
                S_INTERP: begin
                    if (r_phase >= PHASE_ONE) begin
                        r_phase <= r_phase - PHASE_ONE;
                        r_prev  <= r_cur;
                        r_have  <= 1'b1;
                        r_state <= r_last ? S_TRAIL : S_FLUSH;
                    end else if (r_cnt == CNT_MAX) begin
                        // word budget spent: positions still advance
                        r_phase <= r_phase + r_step;
                    end else begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (n_push) begin
                        r_state <= S_INTERP;
                    end
                end
                S_TRAIL: begin
                    if (!trail_ok) begin
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    if (!r_pend_valid || out_free) begin
                        if (r_pend_valid) begin
                            r_out_valid    <= 1'b1;
                            r_out_data     <= r_pend_data;
                            r_out_run_last <= 1'b1;
                            r_out_end      <= r_last;
                            r_pend_valid   <= 1'b0;
                        end
                        if (r_last) begin
                            r_phase <= '0;
                            r_prev  <= '0;
                            r_have  <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
